### rtl/core/mht_pkg.sv
// Shared constants, types and helper functions for the move history table.
package mht_pkg;

    localparam int SQUARES     = 64;
    localparam int MAX_PLY     = 256;
    localparam int SQ_W        = $clog2(SQUARES);
    localparam int PLY_W       = $clog2(MAX_PLY);
    localparam int SQ_AREA     = SQUARES * SQUARES;
    localparam int SCORE_DEPTH = 2 * SQ_AREA;
    localparam int SADDR_W     = $clog2(SCORE_DEPTH);

    localparam int SCORE_W     = 16;
    localparam int MOVE_W      = 16;
    localparam int KENTRY_W    = 2 * MOVE_W;
    localparam int SCALE_W     = 11;
    localparam int CAP_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 16;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RAW_BONUS_W = 20;
    localparam int SUM_W       = 19;

    localparam int GRAV_SHIFT  = 14;
    localparam int GRAVITY     = 1 << GRAV_SHIFT;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(130);
    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(1159);

    localparam logic [CFG_IDX_W-1:0] CFG_BONUS_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BONUS_CAP   = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ACT_REWARD        = 3'd0,
        ACT_PENALIZE      = 3'd1,
        ACT_READ_SCORE    = 3'd2,
        ACT_KILLER_UPDATE = 3'd3,
        ACT_READ_KILLERS  = 3'd4,
        ACT_CLEAR_PLY     = 3'd5,
        ACT_CLEAR_KILLERS = 3'd6,
        ACT_CLEAR_ALL     = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BONUS,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic                clr_one;
        logic                clr_all;
        logic [PLY_W-1:0]    addr;
        logic [KENTRY_W-1:0] wr_data;
    } kcmd_t;

    // Reduces a byte modulo a constant by conditional subtraction of its scaled copies.
    function automatic logic [7:0] mod_byte(input logic [7:0] v, input int m);
        logic [7:0] r;
        r = v;
        for (int k = 7; k >= 0; k--) begin
            if (int'(r) >= (m << k)) begin
                r = r - 8'(m << k);
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/mht_mul.sv
// Shared signed multiplier with a registered product.
module mht_mul (
    input  logic                                aclk,
    input  logic signed [mht_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [mht_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [mht_pkg::PROD_W-1:0]   prod
);
    import mht_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### rtl/core/mht_score_ram.sv
// Score memory with one write port and one registered read port.
module mht_score_ram (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [mht_pkg::SADDR_W-1:0]         wr_addr,
    input  logic signed [mht_pkg::SCORE_W-1:0]  wr_data,
    input  logic                                rd_en,
    input  logic [mht_pkg::SADDR_W-1:0]         rd_addr,
    output logic signed [mht_pkg::SCORE_W-1:0]  rd_data
);
    import mht_pkg::*;

    logic signed [SCORE_W-1:0] mem [SCORE_DEPTH];
    logic signed [SCORE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mht_killer_ram.sv
// Killer pair memory with per-ply valid bits that read as null moves.
module mht_killer_ram (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mht_pkg::kcmd_t                 cmd,
    output logic [mht_pkg::KENTRY_W-1:0]   rd_data
);
    import mht_pkg::*;

    logic [KENTRY_W-1:0] mem [MAX_PLY];
    logic [MAX_PLY-1:0]  valid_reg;
    logic [KENTRY_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[cmd.addr];
            end
            if (cmd.clr_all) begin
                valid_reg <= '0;
            end else if (cmd.clr_one) begin
                valid_reg[cmd.addr] <= 1'b0;
            end else if (cmd.wr_en) begin
                valid_reg[cmd.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/core/move_history_table.sv
// Top level of the move history table: sequencer, configuration and result register.
//
//  Channel   Ports                                   Handshake
//  input     s_action .. s_ply                       s_valid / s_ready
//  result    m_history_score, m_*_killer             m_valid / m_ready
//  config    cfg_index, cfg_wdata                    cfg_we, no wait
//
// An accepted beat passes the read, bonus, multiply and done states to the output
// register, and s_ready rises as it is written there, so no new beat is taken while one
// is in flight. The score and killer reads, the bonus product, the gravity product and the
// final update take one step each, and both products go through one shared multiplier.
// After reset, and after a clear-all action, a sweep zeroes every entry of the score
// memory while s_ready stays low; killers clear at once.
// A stalled result holds in the output register; the next beat may be accepted
// meanwhile and waits at its final step until the register frees.
module move_history_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_action,
    input  logic                  s_side,
    input  logic [5:0]            s_from_square,
    input  logic [5:0]            s_to_square,
    input  logic [3:0]            s_move_flags,
    input  logic [7:0]            s_depth,
    input  logic [7:0]            s_ply,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_history_score,
    output logic [15:0]           m_first_killer,
    output logic [15:0]           m_second_killer,
    input  logic                  cfg_we,
    input  logic [mht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mht_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mht_pkg::*;

    localparam logic [SADDR_W-1:0] SCORE_LAST = SADDR_W'(SCORE_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(GRAVITY);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(GRAVITY);
    localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'(GRAVITY - 1);

    state_t              state_reg, state_next;
    action_t             act_reg;
    logic [SADDR_W-1:0]  saddr_reg;
    logic [PLY_W-1:0]    ply_reg;
    logic [MOVE_W-1:0]   packed_reg;
    logic [7:0]          depth_reg;
    logic [CAP_W-1:0]    bonus_reg, bonus_next;
    logic [SADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SCALE_W-1:0]  scale_reg;
    logic [CAP_W-1:0]    cap_reg;

    logic                  m_valid_reg, m_valid_next;
    logic signed [15:0]    m_score_reg, m_score_next;
    logic [15:0]           m_first_reg, m_first_next;
    logic [15:0]           m_second_reg, m_second_next;

    logic [SQ_W-1:0]       from_mod, to_mod;
    logic [SADDR_W-1:0]    saddr_in;
    logic [PLY_W-1:0]      ply_in;
    logic                  accept;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      sram_we;
    logic [SADDR_W-1:0]        sram_waddr;
    logic signed [SCORE_W-1:0] sram_wdata;
    logic                      sram_re;
    logic signed [SCORE_W-1:0] score_rd;

    kcmd_t                 kcmd;
    logic [KENTRY_W-1:0]   kill_rd;
    logic [MOVE_W-1:0]     kill_first, kill_second;

    logic [RAW_BONUS_W-1:0]    raw_bonus;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [SUM_W-1:0]   quot, delta, sum, sat;
    logic                      out_free;

    assign from_mod = SQ_W'(mod_byte({2'b00, s_from_square}, SQUARES));
    assign to_mod   = SQ_W'(mod_byte({2'b00, s_to_square}, SQUARES));
    assign saddr_in = SADDR_W'(s_side) * SADDR_W'(SQ_AREA)
                    + SADDR_W'(from_mod) * SADDR_W'(SQUARES) + SADDR_W'(to_mod);
    assign ply_in   = PLY_W'(mod_byte(s_ply, MAX_PLY));

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    mht_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    mht_score_ram u_score_ram (
        .aclk    (aclk),
        .wr_en   (sram_we),
        .wr_addr (sram_waddr),
        .wr_data (sram_wdata),
        .rd_en   (sram_re),
        .rd_addr (saddr_reg),
        .rd_data (score_rd)
    );

    mht_killer_ram u_killer_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (kcmd),
        .rd_data (kill_rd)
    );

    assign kill_first  = kill_rd[MOVE_W-1:0];
    assign kill_second = kill_rd[KENTRY_W-1:MOVE_W];

    assign raw_bonus  = prod[RAW_BONUS_W-1:0];
    assign bonus_next = (raw_bonus > RAW_BONUS_W'(cap_reg)) ? cap_reg
                                                           : raw_bonus[CAP_W-1:0];

    // Gravity term rounds toward zero before the shift.
    assign prod_adj = prod + (prod[PROD_W-1] ? ROUND_ADJ : '0);
    assign quot     = prod_adj[PROD_W-1:GRAV_SHIFT];
    assign delta    = (act_reg == ACT_PENALIZE) ? -SUM_W'(bonus_reg) : SUM_W'(bonus_reg);
    assign sum      = SUM_W'(score_rd) + delta - quot;
    assign sat      = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            scale_reg   <= SCALE_RESET;
            cap_reg     <= CAP_RESET;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BONUS_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                    CFG_BONUS_CAP:   cap_reg   <= cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= action_t'(s_action);
            saddr_reg  <= saddr_in;
            ply_reg    <= ply_in;
            packed_reg <= {s_from_square, s_to_square, s_move_flags};
            depth_reg  <= s_depth;
        end
        if (state_reg == ST_BONUS) begin
            bonus_reg <= bonus_next;
        end
        m_score_reg  <= m_score_next;
        m_first_reg  <= m_first_next;
        m_second_reg <= m_second_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_score_next  = m_score_reg;
        m_first_next  = m_first_reg;
        m_second_next = m_second_reg;

        mul_a = MUL_A_W'($signed({1'b0, scale_reg}));
        mul_b = MUL_B_W'($signed({1'b0, depth_reg}));

        sram_we    = 1'b0;
        sram_waddr = saddr_reg;
        sram_wdata = sat[SCORE_W-1:0];
        sram_re    = 1'b0;

        kcmd         = '0;
        kcmd.addr    = ply_reg;
        kcmd.wr_data = {kill_first, packed_reg};

        case (state_reg)
            ST_CLEAR: begin
                sram_we      = 1'b1;
                sram_waddr   = clr_cnt_reg;
                sram_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SCORE_LAST) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                sram_re    = 1'b1;
                kcmd.rd_en = 1'b1;
                state_next = ST_BONUS;
            end
            ST_BONUS: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mul_a      = MUL_A_W'(score_rd);
                mul_b      = MUL_B_W'($signed({1'b0, bonus_reg}));
                state_next = ST_DONE;
            end
            ST_DONE: begin
                mul_a = MUL_A_W'(score_rd);
                mul_b = MUL_B_W'($signed({1'b0, bonus_reg}));
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_score_next  = score_rd;
                    m_first_next  = kill_first;
                    m_second_next = kill_second;
                    state_next    = ST_IDLE;
                    case (act_reg)
                        ACT_REWARD, ACT_PENALIZE: begin
                            sram_we      = 1'b1;
                            m_score_next = sat[SCORE_W-1:0];
                        end
                        ACT_KILLER_UPDATE: begin
                            if (kill_first != packed_reg) begin
                                kcmd.wr_en    = 1'b1;
                                m_first_next  = packed_reg;
                                m_second_next = kill_first;
                            end
                        end
                        ACT_CLEAR_PLY: begin
                            kcmd.clr_one  = 1'b1;
                            m_first_next  = '0;
                            m_second_next = '0;
                        end
                        ACT_CLEAR_KILLERS: begin
                            kcmd.clr_all  = 1'b1;
                            m_first_next  = '0;
                            m_second_next = '0;
                        end
                        ACT_CLEAR_ALL: begin
                            kcmd.clr_all  = 1'b1;
                            m_score_next  = '0;
                            m_first_next  = '0;
                            m_second_next = '0;
                            clr_cnt_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_history_score = m_score_reg;
    assign m_first_killer  = m_first_reg;
    assign m_second_killer = m_second_reg;

endmodule
